[src/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked after the antecedent, quiet while reset is high.
`define ASSERT_IMP_D2(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("assertion failed");

`endif

[src/bcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary cluster stitcher package
// Cluster layout, configuration type, register indexes and reset values.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int SIDE_SLOTS = 3;
  localparam int NUM_PAIRS  = SIDE_SLOTS * SIDE_SLOTS;

  localparam int CLUSTER_W = 42;
  localparam int ENERGY_W  = 12;
  localparam int ET_W      = 10;
  localparam int COORD_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE_ETA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE_ETA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PHI_GAP   = 2'd2;

  localparam logic [COORD_W-1:0] LOW_EDGE_ETA_RST  = 5'd24;
  localparam logic [COORD_W-1:0] HIGH_EDGE_ETA_RST = 5'd0;
  localparam logic [COORD_W-1:0] MAX_PHI_GAP_RST   = 5'd2;

  typedef struct packed {
    logic [COORD_W-1:0]  eta;
    logic [COORD_W-1:0]  phi;
    logic [ET_W-1:0]     et2x5;
    logic [ET_W-1:0]     et5x5;
    logic [ENERGY_W-1:0] energy;
  } cluster_t;

  typedef struct packed {
    logic [COORD_W-1:0] low_edge_eta;
    logic [COORD_W-1:0] high_edge_eta;
    logic [COORD_W-1:0] max_phi_gap;
  } stitch_cfg_t;

endpackage

[src/bcs_pair_stitch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary cluster pair stitch
// Merges a lower/higher pair when both sit on the edge and phi is close; the
// higher-energy one (lower on a tie) takes the sums, the other loses energy.
// ----------------------------------------------------------------------------
module bcs_pair_stitch (
  input  bcs_pkg::stitch_cfg_t cfg,
  input  bcs_pkg::cluster_t    lo_in,
  input  bcs_pkg::cluster_t    hi_in,
  output bcs_pkg::cluster_t    lo_out,
  output bcs_pkg::cluster_t    hi_out
);

  logic [bcs_pkg::COORD_W-1:0]  gap;
  logic                         hit;
  logic                         hi_wins;
  logic [bcs_pkg::ENERGY_W-1:0] esum;
  logic [bcs_pkg::ET_W-1:0]     s5;
  logic [bcs_pkg::ET_W-1:0]     s2;

  assign gap = (lo_in.phi >= hi_in.phi) ? (lo_in.phi - hi_in.phi)
                                        : (hi_in.phi - lo_in.phi);
  assign hit = (lo_in.eta == cfg.low_edge_eta) && (hi_in.eta == cfg.high_edge_eta) &&
               (gap <= cfg.max_phi_gap);
  assign hi_wins = hi_in.energy > lo_in.energy;

  // sums wrap at field width
  assign esum = lo_in.energy + hi_in.energy;
  assign s5   = lo_in.et5x5 + hi_in.et5x5;
  assign s2   = lo_in.et2x5 + hi_in.et2x5;

  always_comb begin
    lo_out = lo_in;
    hi_out = hi_in;
    if (hit) begin
      if (hi_wins) begin
        hi_out.energy = esum;
        hi_out.et5x5  = s5;
        hi_out.et2x5  = s2;
        lo_out.energy = '0;
      end else begin
        lo_out.energy = esum;
        lo_out.et5x5  = s5;
        lo_out.et2x5  = s2;
        hi_out.energy = '0;
      end
    end
  end

endmodule

[src/boundary_cluster_stitcher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary cluster stitcher core
// Stitches clusters split across a region border, one transaction per cycle.
// ----------------------------------------------------------------------------
// Pipeline: an accepted transaction passes the input register, then the result
//   register around a chain of up to nine pair stitch units, and done pulses.
// Throughput: one transaction per cycle; busy is high only during reset.
// Each result shows for one cycle on done; the receiver cannot stall.
// Reset clears the pipeline valid bits and loads the edge registers with
//   eta 24 / eta 0 / phi gap 2.
module boundary_cluster_stitcher_core #(
  parameter int EDGE_CLUSTERS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  output logic                             done,
  input  logic                             cfg_write,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcs_pkg::COORD_W-1:0]      cfg_data,
  input  logic [bcs_pkg::CLUSTER_W-1:0]    low_cluster_a,
  input  logic [bcs_pkg::CLUSTER_W-1:0]    low_cluster_b,
  input  logic [bcs_pkg::CLUSTER_W-1:0]    low_cluster_c,
  input  logic [bcs_pkg::CLUSTER_W-1:0]    high_cluster_a,
  input  logic [bcs_pkg::CLUSTER_W-1:0]    high_cluster_b,
  input  logic [bcs_pkg::CLUSTER_W-1:0]    high_cluster_c,
  output logic [bcs_pkg::CLUSTER_W-1:0]    merged_low_a,
  output logic [bcs_pkg::CLUSTER_W-1:0]    merged_low_b,
  output logic [bcs_pkg::CLUSTER_W-1:0]    merged_low_c,
  output logic [bcs_pkg::CLUSTER_W-1:0]    merged_high_a,
  output logic [bcs_pkg::CLUSTER_W-1:0]    merged_high_b,
  output logic [bcs_pkg::CLUSTER_W-1:0]    merged_high_c
);

  localparam int SLOTS  = bcs_pkg::SIDE_SLOTS;
  localparam int NPAIRS = bcs_pkg::NUM_PAIRS;
  localparam int ACTIVE = (EDGE_CLUSTERS > SLOTS) ? SLOTS : EDGE_CLUSTERS;

  bcs_pkg::stitch_cfg_t cfg;
  logic                 in_valid;
  bcs_pkg::cluster_t    lo_q  [SLOTS];
  bcs_pkg::cluster_t    hi_q  [SLOTS];
  bcs_pkg::cluster_t    lo_ch [NPAIRS+1][SLOTS];
  bcs_pkg::cluster_t    hi_ch [NPAIRS+1][SLOTS];
  bcs_pkg::cluster_t    lo_res [SLOTS];
  bcs_pkg::cluster_t    hi_res [SLOTS];
  logic                 accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // Edge registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_edge_eta  <= bcs_pkg::LOW_EDGE_ETA_RST;
      cfg.high_edge_eta <= bcs_pkg::HIGH_EDGE_ETA_RST;
      cfg.max_phi_gap   <= bcs_pkg::MAX_PHI_GAP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bcs_pkg::REG_LOW_EDGE_ETA:  cfg.low_edge_eta  <= cfg_data;
        bcs_pkg::REG_HIGH_EDGE_ETA: cfg.high_edge_eta <= cfg_data;
        bcs_pkg::REG_MAX_PHI_GAP:   cfg.max_phi_gap   <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_q[0] <= bcs_pkg::cluster_t'(low_cluster_a);
      lo_q[1] <= bcs_pkg::cluster_t'(low_cluster_b);
      lo_q[2] <= bcs_pkg::cluster_t'(low_cluster_c);
      hi_q[0] <= bcs_pkg::cluster_t'(high_cluster_a);
      hi_q[1] <= bcs_pkg::cluster_t'(high_cluster_b);
      hi_q[2] <= bcs_pkg::cluster_t'(high_cluster_c);
    end
  end

  // Pair chain: lower index outer, higher index inner
  genvar s, k;
  generate
    for (s = 0; s < SLOTS; s++) begin : g_head
      assign lo_ch[0][s] = lo_q[s];
      assign hi_ch[0][s] = hi_q[s];
    end

    for (k = 0; k < NPAIRS; k++) begin : g_pair
      localparam int J = k / SLOTS;
      localparam int I = k % SLOTS;
      for (s = 0; s < SLOTS; s++) begin : g_pass
        if (s != J) begin : g_lo
          assign lo_ch[k+1][s] = lo_ch[k][s];
        end
        if (s != I) begin : g_hi
          assign hi_ch[k+1][s] = hi_ch[k][s];
        end
      end
      if (J < ACTIVE && I < ACTIVE) begin : g_unit
        bcs_pair_stitch u_stitch (
          .cfg    (cfg),
          .lo_in  (lo_ch[k][J]),
          .hi_in  (hi_ch[k][I]),
          .lo_out (lo_ch[k+1][J]),
          .hi_out (hi_ch[k+1][I])
        );
      end else begin : g_skip
        assign lo_ch[k+1][J] = lo_ch[k][J];
        assign hi_ch[k+1][I] = hi_ch[k][I];
      end
    end
  endgenerate

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      for (int n = 0; n < SLOTS; n++) begin
        lo_res[n] <= lo_ch[NPAIRS][n];
        hi_res[n] <= hi_ch[NPAIRS][n];
      end
    end
  end

  assign merged_low_a  = lo_res[0];
  assign merged_low_b  = lo_res[1];
  assign merged_low_c  = lo_res[2];
  assign merged_high_a = hi_res[0];
  assign merged_high_b = hi_res[1];
  assign merged_high_c = hi_res[2];

endmodule

[src/bcs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary cluster stitcher checker
// Port-level checks on transaction timing and untouched cluster fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [bcs_pkg::CLUSTER_W-1:0] low_cluster_a,
  input logic [bcs_pkg::CLUSTER_W-1:0] high_cluster_c,
  input logic [bcs_pkg::CLUSTER_W-1:0] merged_low_a,
  input logic [bcs_pkg::CLUSTER_W-1:0] merged_high_c
);

  // every accepted transaction yields a result
  `ASSERT_IMP_D2(a_accept_gives_done, clk, rst, start && !busy, done)

  // no result without an accepted transaction
  `ASSERT_IMP(a_done_has_source, clk, rst, done, $past(start && !busy, 2))

  // stitching never moves phi or eta
  `ASSERT_IMP(a_low_coords_kept, clk, rst, done, merged_low_a[41:32] == $past(low_cluster_a[41:32], 2))
  `ASSERT_IMP(a_high_coords_kept, clk, rst, done, merged_high_c[41:32] == $past(high_cluster_c[41:32], 2))

endmodule

bind boundary_cluster_stitcher_core bcs_checker u_bcs_checker (.*);
